/* rtl/ordered_list_append_delete_macros.svh */
// Assertion macros shared by the ordered list RTL.
// Each expects clk and rst_n in scope of the module that uses it.
`ifndef ORDERED_LIST_APPEND_DELETE_MACROS_SVH
`define ORDERED_LIST_APPEND_DELETE_MACROS_SVH

// same-cycle implication
`define OLAD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OLAD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/olad_pkg.sv */
// Shared types and constants for the ordered list block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package olad_pkg;

  localparam int LIST_DEPTH_DEF = 32;
  localparam int DATA_W         = 32;
  localparam int CNT_W          = 6;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef enum logic [2:0] {
    ST_APPENDED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPEND,
    S_WALK
  } olad_state_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    append;
    logic    walk;
    logic    finish;
    status_t code;
  } olad_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic hit;
    logic walk_last;
  } olad_sts_t;

endpackage

`default_nettype wire

/* rtl/ordered_list_append_delete.sv */
// Top level of the ordered list block: joins sequencer and datapath.
// Depends on olad_pkg, olad_ctrl and olad_dpath.
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of signed 32-bit values with append-at-tail and
// delete-first-match. A transaction is taken when start is high and busy is
// low; exactly one result follows, shown for a single cycle with out_valid
// high. The receiver cannot stall: sample the result in that cycle. An append
// is carried out in the S_APPEND state that follows acceptance. A delete walks
// the whole list in S_WALK, ending at once on an empty list, paced by the single read
// port of the entry store: the walk reads one entry per cycle, compares it
// and, past the match, writes it back one place up. busy drops in the strobe
// cycle, so the next transaction may be taken there. No clearing pass after
// reset.
module ordered_list_append_delete #(
  parameter int LIST_DEPTH = olad_pkg::LIST_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               in_operation,
  input  wire logic signed [olad_pkg::DATA_W-1:0] in_value,
  output logic                                    out_valid,
  output logic [2:0]                              out_status,
  output logic [olad_pkg::CNT_W-1:0]              out_entry_count
);
  import olad_pkg::*;

  olad_cmd_t cmd;
  olad_sts_t sts;

  olad_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy),
    .out_valid    (out_valid)
  );

  olad_dpath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_value        (in_value),
    .sts             (sts),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

endmodule

`default_nettype wire

/* rtl/olad_ctrl.sv */
// Sequencer for the ordered list: accepts transactions, steps append and
// delete walks, raises the result strobe. Depends on olad_pkg and the macros header.
`timescale 1ns / 1ps
`default_nettype none

module olad_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              in_operation,
  input  wire olad_pkg::olad_sts_t sts,
  output olad_pkg::olad_cmd_t    cmd,
  output logic                   busy,
  output logic                   out_valid
);
  import olad_pkg::*;

  olad_state_t state_r, state_nxt;
  logic        out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = (in_operation == OP_DELETE) ? S_WALK : S_APPEND;
        end
      end
      S_APPEND: state_nxt = S_IDLE;
      S_WALK: begin
        if (sts.empty || sts.walk_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.code = ST_APPENDED;
    unique case (state_r)
      S_IDLE: cmd.load = start;
      S_APPEND: begin
        cmd.append = 1'b1;
        cmd.finish = 1'b1;
        cmd.code   = sts.full ? ST_FULL : ST_APPENDED;
      end
      S_WALK: begin
        if (sts.empty) begin
          cmd.finish = 1'b1;
          cmd.code   = ST_EMPTY;
        end else begin
          cmd.walk = 1'b1;
          if (sts.walk_last) begin
            cmd.finish = 1'b1;
            cmd.code   = sts.hit ? ST_DELETED : ST_NOT_FOUND;
          end
        end
      end
      default: cmd = '0;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`include "ordered_list_append_delete_macros.svh"

  `OLAD_ASSERT_NXT(a_finish_strobe, cmd.finish, out_valid_r, "finish without strobe")
  `OLAD_ASSERT_NXT(a_strobe_single, out_valid_r, !out_valid_r, "strobe held two cycles")
  `OLAD_ASSERT_NXT(a_accept_moves, start && !busy, state_r == S_APPEND || state_r == S_WALK, "accepted transaction not started")

endmodule

`default_nettype wire

/* rtl/olad_dpath.sv */
// Datapath for the ordered list: entry store, length, walk pointers and
// result registers. Depends on olad_pkg and the macros header.
`timescale 1ns / 1ps
`default_nettype none

module olad_dpath #(
  parameter int LIST_DEPTH = olad_pkg::LIST_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire olad_pkg::olad_cmd_t         cmd,
  input  wire logic signed [olad_pkg::DATA_W-1:0] in_value,
  output olad_pkg::olad_sts_t              sts,
  output logic [2:0]                       out_status,
  output logic [olad_pkg::CNT_W-1:0]       out_entry_count
);
  import olad_pkg::*;

  localparam int IW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);

  logic [DATA_W-1:0] mem [LIST_DEPTH];

  logic [DATA_W-1:0] value_r;
  logic [DATA_W-1:0] rdata_r;
  logic [CW-1:0]     len_r, len_nxt;
  logic [CW-1:0]     rd_ptr_r;
  logic [CW-1:0]     dat_ptr_r;
  logic              dat_vld_r;
  logic              found_r;
  logic [2:0]        status_r;
  logic [CNT_W-1:0]  count_r;

  logic              rd_en;
  logic              match_now;
  logic              append_ok;
  logic              shift_we;
  logic              mem_we;
  logic [IW-1:0]     wr_idx;
  logic [DATA_W-1:0] wr_data;
  logic [CW-1:0]     shift_ptr;
  logic [CW+CNT_W-1:0] len_ext;

  assign sts.full  = (len_r == CW'(LIST_DEPTH));
  assign sts.empty = (len_r == '0);

  assign rd_en     = cmd.walk && (rd_ptr_r < len_r);
  assign match_now = dat_vld_r && !found_r && (rdata_r == value_r);
  assign sts.hit   = found_r || match_now;
  assign sts.walk_last = dat_vld_r && (dat_ptr_r == len_r - CW'(1));

  // entries behind the hole move up one place as they stream past
  assign shift_ptr = dat_ptr_r - CW'(1);
  assign append_ok = cmd.append && !sts.full;
  assign shift_we  = cmd.walk && dat_vld_r && found_r;
  assign mem_we    = append_ok || shift_we;
  assign wr_idx    = append_ok ? len_r[IW-1:0] : shift_ptr[IW-1:0];
  assign wr_data   = append_ok ? value_r : rdata_r;

  always_comb begin
    len_nxt = len_r;
    priority if (append_ok) begin
      len_nxt = len_r + CW'(1);
    end else if (cmd.finish && cmd.code == ST_DELETED) begin
      len_nxt = len_r - CW'(1);
    end
  end

  // count reports the low bits of the length
  assign len_ext = {{CNT_W{1'b0}}, len_nxt};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_ptr_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= in_value;
    end
    if (cmd.finish) begin
      status_r <= cmd.code;
      count_r  <= len_ext[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      rd_ptr_r  <= '0;
      dat_ptr_r <= '0;
      dat_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      len_r <= len_nxt;
      if (cmd.load) begin
        rd_ptr_r  <= '0;
        dat_vld_r <= 1'b0;
        found_r   <= 1'b0;
      end else if (cmd.walk) begin
        rd_ptr_r  <= rd_ptr_r + CW'(rd_en);
        dat_ptr_r <= rd_ptr_r;
        dat_vld_r <= rd_en;
        if (match_now) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  assign out_status      = status_r;
  assign out_entry_count = count_r;

`include "ordered_list_append_delete_macros.svh"

  `OLAD_ASSERT_IMP(a_len_bound, 1'b1, len_r <= CW'(LIST_DEPTH), "length beyond depth")
  `OLAD_ASSERT_IMP(a_shift_after_hit, shift_we, found_r && !append_ok, "shift write before match")
  `OLAD_ASSERT_NXT(a_delete_shrinks, cmd.finish && cmd.code == ST_DELETED, len_r == $past(len_r) - CW'(1), "delete did not shrink list")

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for ordered_list_append_delete: append/delete traffic with scoreboard.
// Depends on olad_pkg and the ordered_list_append_delete RTL.
`timescale 1ns / 1ps

module testbench;
  import olad_pkg::*;

  localparam int DEPTH = LIST_DEPTH_DEF;
  localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;

  typedef struct packed {
    logic              op;
    logic [DATA_W-1:0] value;
  } list_op_t;

  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] count;
  } list_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic in_operation = OP_APPEND;
  logic signed [DATA_W-1:0] in_value = '0;
  logic busy;
  logic out_valid;
  logic [2:0] out_status;
  logic [CNT_W-1:0] out_entry_count;

  ordered_list_append_delete u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // two copies of the list: [0] tracks the DUT for checking, [1] shapes stimulus
  logic [DATA_W-1:0] entries [2][DEPTH];
  int                fill [2];

  list_op_t    op_queue [$];
  list_reply_t reply_queue [$];
  list_op_t    next_op;
  list_reply_t got;

  int  idle_pct = 0;
  bit  on_bus = 1'b0;
  bit  took = 1'b0;
  bit  filling = 1'b1;
  int  fail_count = 0;
  int  xact_count = 0;
  int  status_hits [5];
  int  peak_count = 0;

  function automatic status_t list_update(input int m, input logic op,
                                          input logic [DATA_W-1:0] v);
    int i;
    int hit;
    if (op == OP_APPEND) begin
      if (fill[m] >= DEPTH) return ST_FULL;
      entries[m][fill[m]] = v;
      fill[m]++;
      return ST_APPENDED;
    end
    if (fill[m] == 0) return ST_EMPTY;
    hit = -1;
    for (i = 0; i < fill[m]; i++)
      if (hit < 0 && entries[m][i] == v) hit = i;
    if (hit < 0) return ST_NOT_FOUND;
    for (i = hit; i + 1 < fill[m]; i++)
      entries[m][i] = entries[m][i + 1];
    fill[m]--;
    return ST_DELETED;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int k;
    case ($urandom_range(9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2, 3, 4: begin
        // small pool so duplicates show up often
        k = $urandom_range(7) - 4;
        return k;
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(input logic op, input logic [DATA_W-1:0] v);
    list_op_t item;
    item.op = op;
    item.value = v;
    void'(list_update(1, op, v));
    op_queue.push_back(item);
  endtask

  task automatic add_random_item();
    logic op;
    logic [DATA_W-1:0] v;
    if (fill[1] == DEPTH) filling = 1'b0;
    else if (fill[1] == 0) filling = 1'b1;
    if ($urandom_range(9) == 0) begin
      op = 1'($urandom_range(1));
      v = $urandom;
    end else begin
      // alternate fill and drain sweeps so full and empty are both hit
      op = ($urandom_range(99) < (filling ? 25 : 75)) ? OP_DELETE : OP_APPEND;
      if (op == OP_DELETE && fill[1] > 0 && $urandom_range(99) < 70)
        v = entries[1][$urandom_range(fill[1] - 1)];
      else
        v = pick_value();
    end
    add_item(op, v);
  endtask

  task automatic wait_quiet();
    while (op_queue.size() != 0 || on_bus || reply_queue.size() != 0)
      @(posedge clk);
  endtask

  // driver: present the next transaction at the falling edge
  always @(negedge clk) begin
    if (took) on_bus = 1'b0;
    if (rst_n && !on_bus && op_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
      next_op = op_queue.pop_front();
      in_operation <= next_op.op;
      in_value <= next_op.value;
      on_bus = 1'b1;
    end
    start <= on_bus;
  end

  // monitor: check the strobed result, then predict for a newly taken transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      took <= 1'b0;
    end else begin
      if (out_valid) begin
        if (out_status <= ST_FULL) status_hits[out_status]++;
        if (out_entry_count > peak_count) peak_count = out_entry_count;
        if (reply_queue.size() == 0) begin
          $error("out_valid with no transaction outstanding");
          fail_count++;
        end else begin
          got = reply_queue.pop_front();
          if (out_status !== got.status) begin
            $error("out_status: expected %0d, got %0d", got.status, out_status);
            fail_count++;
          end
          if (out_entry_count !== got.count) begin
            $error("out_entry_count: expected %0d, got %0d", got.count, out_entry_count);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        got.status = list_update(0, in_operation, in_value);
        got.count = CNT_W'(fill[0]);
        reply_queue.push_back(got);
        xact_count++;
      end
      took <= start && !busy;
    end
  end

  initial begin
    fill[0] = 0;
    fill[1] = 0;
    foreach (status_hits[i]) status_hits[i] = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, duplicates, empty and not-found cases
    add_item(OP_DELETE, 32'd0);
    add_item(OP_APPEND, VAL_MAX);
    add_item(OP_APPEND, VAL_MIN);
    add_item(OP_APPEND, 32'd0);
    add_item(OP_APPEND, 32'hFFFF_FFFF);
    add_item(OP_APPEND, 32'hFFFF_FFFF);
    add_item(OP_APPEND, 32'd1);
    add_item(OP_DELETE, 32'hFFFF_FFFF);
    add_item(OP_DELETE, 32'd5);
    add_item(OP_DELETE, VAL_MAX);
    add_item(OP_DELETE, 32'd1);
    add_item(OP_DELETE, VAL_MIN);
    add_item(OP_DELETE, 32'hFFFF_FFFF);
    add_item(OP_DELETE, 32'hFFFF_FFFF);
    add_item(OP_DELETE, 32'd0);
    add_item(OP_DELETE, VAL_MIN);
    add_item(OP_APPEND, 32'h5555_5555);
    add_item(OP_APPEND, 32'hAAAA_AAAA);
    add_item(OP_DELETE, 32'hAAAA_AAAA);
    add_item(OP_DELETE, 32'h5555_5555);

    idle_pct = 0;
    repeat (600) add_random_item();
    wait_quiet();

    idle_pct = 88;
    repeat (400) add_random_item();
    wait_quiet();

    idle_pct = 25;
    repeat (800) add_random_item();
    wait_quiet();

    repeat (50) @(posedge clk);
    if (reply_queue.size() != 0) begin
      $error("%0d results never arrived", reply_queue.size());
      fail_count++;
    end

    $display("Run covered %0d transactions, peak list length %0d.", xact_count, peak_count);
    $display("Results: %0d appended, %0d deleted, %0d not found, %0d empty, %0d full.",
             status_hits[ST_APPENDED], status_hits[ST_DELETED], status_hits[ST_NOT_FOUND],
             status_hits[ST_EMPTY], status_hits[ST_FULL]);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* ordered_list_append_delete.f */
+incdir+rtl
rtl/olad_pkg.sv
rtl/olad_ctrl.sv
rtl/olad_dpath.sv
rtl/ordered_list_append_delete.sv
bench/testbench.sv
